[hdl/lvwd_pkg.sv]
`default_nettype none
package lvwd_pkg;

   localparam int unsigned CLEAR_CODE    = 256;
   localparam int unsigned END_CODE      = 257;
   localparam int unsigned FIRST_FREE    = 258;
   localparam int unsigned START_WIDTH   = 9;
   localparam int unsigned MAX_OUT_BYTES = 256;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_END      = 2'd1,
      ST_INVALID  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_stream;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  byte_count;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/lvwd_ram.sv]
`default_nettype none
module lvwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hdl/lvwd_extract.sv]
`default_nettype none
module lvwd_extract #(
   parameter int MAX_CODE_BITS = 9
) (
   input  wire logic [MAX_CODE_BITS-2:0] buf_cur,
   input  wire logic [4:0]               cnt_cur,
   input  wire logic [4:0]               width,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     last_byte,
   output logic                          have_code,
   output logic      [MAX_CODE_BITS-1:0] code,
   output logic      [MAX_CODE_BITS-2:0] buf_next,
   output logic      [4:0]               cnt_next
);

   localparam int BW = MAX_CODE_BITS - 1;
   localparam int CW = BW + 8;

   logic [CW-1:0] cat;
   logic [CW-1:0] shifted;
   logic [CW-1:0] rest;
   logic [4:0]    bc;
   logic [4:0]    rem;

   always_comb begin
      cat       = {buf_cur, data_byte};
      bc        = cnt_cur + 5'd8;
      rem       = '0;
      shifted   = '0;
      rest      = '0;
      have_code = 1'b0;
      code      = '0;
      buf_next  = cat[BW-1:0];
      cnt_next  = bc;
      if (bc >= width) begin
         rem       = bc - width;
         shifted   = cat >> rem;
         rest      = cat & ~({CW{1'b1}} << rem);
         have_code = 1'b1;
         code      = shifted[MAX_CODE_BITS-1:0];
         buf_next  = rest[BW-1:0];
         cnt_next  = rem;
      end else if (last_byte) begin
         // zero-pad the partial code
         shifted   = cat << (width - bc);
         have_code = 1'b1;
         code      = shifted[MAX_CODE_BITS-1:0];
      end
      if (last_byte) begin
         buf_next = '0;
         cnt_next = '0;
      end
   end

endmodule
`default_nettype wire

[hdl/lzw_variable_width_decoder.sv]
// a byte with no code or a clear code is taken in S_IDLE; an end or bad code then passes S_STAT
// a code walks the dictionary through S_WALK and S_WAIT per non-root node (S_WALK alone for the
// entry still being built) and S_WALK for the root, then reads back through S_POP and S_PWAIT
// per further byte and S_FLUSH per result, plus any output stall
// throughput: one byte at a time; the next byte is taken when the last result is loaded
// reset: synchronous, clears control state; memories are not cleared since every
// dictionary entry is written before it is read
`default_nettype none
module lzw_variable_width_decoder
   import lvwd_pkg::*;
#(
   parameter int MAX_CODE_BITS = 9
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW    = MAX_CODE_BITS;
   localparam int NW    = MAX_CODE_BITS + 1;
   localparam int DEPTH = 1 << MAX_CODE_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_STAT, S_WALK, S_WAIT, S_POP, S_PWAIT, S_FLUSH
   } state_type;

   state_type       state_ff, state_in;
   logic [NW-1:0]   nfc_ff, nfc_in;
   logic [4:0]      width_ff, width_in;
   logic [AW-2:0]   buf_ff, buf_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            halted_ff, halted_in;
   logic [AW-1:0]   prev_ff, prev_in;
   logic [AW-1:0]   c_ff, c_in;
   logic            kwk_ff, kwk_in;
   logic [AW-1:0]   entry_ff, entry_in;
   logic [AW-1:0]   eprev_ff, eprev_in;
   status_type      st_ff, st_in;
   logic [AW-1:0]   depth_ff, depth_in;
   logic [7:0]      root_ff, root_in;
   logic [63:0]     word_ff, word_in;
   logic [3:0]      wcnt_ff, wcnt_in;
   logic [8:0]      emit_ff, emit_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [NW-1:0]   nfc_e;
   logic [4:0]      width_e;
   logic [AW-2:0]   buf_e;
   logic [4:0]      cnt_e;
   logic            halted_e;
   logic            have_code;
   logic [AW-1:0]   code;
   logic [AW-2:0]   buf_next;
   logic [4:0]      cnt_next;
   logic [NW-1:0]   nfc_inc;
   logic [NW:0]     pow_w;
   logic            out_free;
   logic            done;
   logic [7:0]      pop_byte;

   logic            d_we, d_re, s_we, s_re;
   logic [AW-1:0]   d_waddr, d_raddr, s_waddr, s_raddr;
   logic [AW+7:0]   d_wdata, d_rdata;
   logic [7:0]      s_wdata, s_rdata;

   lvwd_extract #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_extract (
      .buf_cur   (buf_e),
      .cnt_cur   (cnt_e),
      .width     (width_e),
      .data_byte (req_data.data_byte),
      .last_byte (req_data.last_byte),
      .have_code (have_code),
      .code      (code),
      .buf_next  (buf_next),
      .cnt_next  (cnt_next)
   );

   // entry = {prefix code, appended char}
   lvwd_ram #(.WIDTH(AW + 8), .DEPTH(DEPTH)) u_dict (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_en   (d_re),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   // chars of the chain, pushed code first, popped root side first
   lvwd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign done      = (depth_ff == '0) || (emit_ff == 9'(MAX_OUT_BYTES));
   assign pop_byte  = (depth_ff == AW'(1) && kwk_ff) ? root_ff : s_rdata;

   always_comb begin
      if (req_data.first_of_stream) begin
         nfc_e    = NW'(FIRST_FREE);
         width_e  = 5'(START_WIDTH);
         buf_e    = '0;
         cnt_e    = '0;
         halted_e = 1'b0;
      end else begin
         nfc_e    = nfc_ff;
         width_e  = width_ff;
         buf_e    = buf_ff;
         cnt_e    = cnt_ff;
         halted_e = halted_ff;
      end
      nfc_inc = nfc_e + NW'(1);
      pow_w   = (NW+1)'(1) << width_e;
   end

   always_comb begin
      state_in     = state_ff;
      nfc_in       = nfc_ff;
      width_in     = width_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      halted_in    = halted_ff;
      prev_in      = prev_ff;
      c_in         = c_ff;
      kwk_in       = kwk_ff;
      entry_in     = entry_ff;
      eprev_in     = eprev_ff;
      st_in        = st_ff;
      depth_in     = depth_ff;
      root_in      = root_ff;
      word_in      = word_ff;
      wcnt_in      = wcnt_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      d_we = 1'b0; d_waddr = entry_ff; d_wdata = {eprev_ff, c_ff[7:0]};
      d_re = 1'b0; d_raddr = c_ff;
      s_we = 1'b0; s_waddr = depth_ff; s_wdata = d_rdata[7:0];
      s_re = 1'b0; s_raddr = depth_ff - AW'(1);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               nfc_in    = nfc_e;
               width_in  = width_e;
               buf_in    = buf_e;
               cnt_in    = cnt_e;
               halted_in = halted_e;
               if (!halted_e) begin
                  buf_in = buf_next;
                  cnt_in = cnt_next;
                  if (have_code) begin
                     if (code == AW'(END_CODE)) begin
                        halted_in = 1'b1;
                        st_in     = ST_END;
                        state_in  = S_STAT;
                     end else if (code == AW'(CLEAR_CODE)) begin
                        nfc_in   = NW'(FIRST_FREE);
                        width_in = 5'(START_WIDTH);
                     end else if ((NW'(code) >= nfc_e) || (nfc_e >= NW'(DEPTH))) begin
                        halted_in = 1'b1;
                        st_in     = ST_INVALID;
                        state_in  = S_STAT;
                     end else begin
                        kwk_in   = (NW'(code) == nfc_e - NW'(1));
                        entry_in = AW'(nfc_e - NW'(1));
                        eprev_in = prev_ff;
                        prev_in  = code;
                        c_in     = code;
                        depth_in = '0;
                        nfc_in   = nfc_inc;
                        st_in    = ST_OK;
                        if ((NW+1)'(nfc_inc) >= pow_w) begin
                           if (32'(width_e) + 32'd1 > 32'(MAX_CODE_BITS)) begin
                              st_in     = ST_OVERFLOW;
                              halted_in = 1'b1;
                           end else begin
                              width_in = width_e + 5'd1;
                           end
                        end
                        state_in = S_WALK;
                     end
                  end
               end
            end
         end
         S_WALK: begin
            if (c_ff[AW-1:8] == '0) begin
               // root reached: its char completes the previous entry
               root_in  = c_ff[7:0];
               d_we     = 1'b1;
               word_in  = {56'd0, c_ff[7:0]};
               wcnt_in  = 4'd1;
               emit_in  = 9'd1;
               state_in = S_POP;
            end else if (c_ff == entry_ff) begin
               // entry not yet complete: prefix is the previous code, char is the root
               s_we     = 1'b1;
               depth_in = depth_ff + AW'(1);
               c_in     = eprev_ff;
            end else begin
               d_re     = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            s_we     = 1'b1;
            depth_in = depth_ff + AW'(1);
            c_in     = d_rdata[AW+7:8];
            state_in = S_WALK;
         end
         S_POP: begin
            if (done || wcnt_ff == 4'd8) begin
               state_in = S_FLUSH;
            end else begin
               s_re     = 1'b1;
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            word_in  = word_ff | ({56'd0, pop_byte} << {wcnt_ff[2:0], 3'b000});
            wcnt_in  = wcnt_ff + 4'd1;
            emit_in  = emit_ff + 9'd1;
            depth_in = depth_ff - AW'(1);
            state_in = S_POP;
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.out_bytes    = word_ff;
               rsp_in.byte_count   = wcnt_ff;
               rsp_in.status       = done ? st_ff : ST_OK;
               rsp_in.last_of_run  = done;
               word_in             = '0;
               wcnt_in             = '0;
               state_in            = done ? S_IDLE : S_POP;
            end
         end
         S_STAT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_bytes   = '0;
               rsp_in.byte_count  = '0;
               rsp_in.status      = st_ff;
               rsp_in.last_of_run = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nfc_ff       <= NW'(FIRST_FREE);
         width_ff     <= 5'(START_WIDTH);
         buf_ff       <= '0;
         cnt_ff       <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nfc_ff       <= nfc_in;
         width_ff     <= width_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      c_ff     <= c_in;
      kwk_ff   <= kwk_in;
      entry_ff <= entry_in;
      eprev_ff <= eprev_in;
      st_ff    <= st_in;
      depth_ff <= depth_in;
      root_ff  <= root_in;
      word_ff  <= word_in;
      wcnt_ff  <= wcnt_in;
      emit_ff  <= emit_in;
      rsp_ff   <= rsp_in;
   end

endmodule
`default_nettype wire

[hdl/lvwd_checker.sv]
`default_nettype none
module lvwd_checker
   import lvwd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // only the last result of a string may be short
   a_full_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> rsp_data.byte_count == 4'd8)
      else $error("non-final result not full");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last_of_run)
      else $error("status on a non-final result");

   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_END || rsp_data.status == ST_INVALID)
      |-> rsp_data.byte_count == 4'd0 && rsp_data.out_bytes == 64'd0)
      else $error("end or invalid result carries bytes");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_count <= 4'd8)
      else $error("byte count out of range");

endmodule

bind lzw_variable_width_decoder lvwd_checker u_lvwd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

[sim/tb_lzw_variable_width_decoder.sv]
`default_nettype none
module tb_lzw_variable_width_decoder;
   import lvwd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_BITS   = 9;
   localparam int unsigned DICT_DEPTH = 1 << MAX_BITS;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   lzw_variable_width_decoder #(.MAX_CODE_BITS(MAX_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // decoder mirror
   logic [15:0] prefix_mem[DICT_DEPTH];
   logic [15:0] link_mem[DICT_DEPTH];
   logic [7:0]  char_mem[DICT_DEPTH];
   int unsigned free_code;
   int unsigned code_bits;
   int unsigned bit_buf;
   int unsigned bit_cnt;
   bit          stopped;

   rsp_type     decoded_q[$];
   int          error_count;
   bit          quiet;
   bit          hold_request;
   int          stall_left;

   function automatic void clear_dict();
      for (int i = 0; i < DICT_DEPTH; i++) begin
         prefix_mem[i] = '0;
         link_mem[i]   = '0;
         char_mem[i]   = (i < 256) ? i[7:0] : 8'd0;
      end
      free_code = FIRST_FREE;
      code_bits = START_WIDTH;
   endfunction

   function automatic void push_status(status_type st);
      rsp_type r;
      r.out_bytes   = '0;
      r.byte_count  = '0;
      r.status      = st;
      r.last_of_run = 1'b1;
      decoded_q.push_back(r);
   endfunction

   function automatic void decode_byte(req_type item);
      int unsigned code, c, t, guard, n, nres, cnt;
      status_type  st;
      logic [7:0]  text[MAX_OUT_BYTES];
      rsp_type     r;
      if (item.first_of_stream) begin
         clear_dict();
         bit_buf = 0;
         bit_cnt = 0;
         stopped = 1'b0;
      end
      if (stopped) return;
      bit_cnt += 8;
      bit_buf = ((bit_buf << 8) | item.data_byte) & ((32'd1 << bit_cnt) - 1);
      if (bit_cnt < code_bits) begin
         if (!item.last_byte) return;
         bit_buf = bit_buf << (code_bits - bit_cnt);
         bit_cnt = code_bits;
      end
      bit_cnt -= code_bits;
      code = bit_buf >> bit_cnt;
      bit_buf &= (32'd1 << bit_cnt) - 1;
      if (item.last_byte) begin
         bit_buf = 0;
         bit_cnt = 0;
      end
      if (code == END_CODE) begin
         stopped = 1'b1;
         push_status(ST_END);
         return;
      end
      if (code == CLEAR_CODE) begin
         clear_dict();
         return;
      end
      if (code >= free_code || code >= DICT_DEPTH || free_code >= DICT_DEPTH) begin
         stopped = 1'b1;
         push_status(ST_INVALID);
         return;
      end
      prefix_mem[free_code] = 16'(code);
      c = code;
      for (guard = 0; c > 255 && guard < DICT_DEPTH; guard++) begin
         t = prefix_mem[c] & (DICT_DEPTH - 1);
         link_mem[t] = 16'(c);
         c = t;
      end
      c &= DICT_DEPTH - 1;
      char_mem[free_code - 1] = char_mem[c];
      n = 0;
      for (guard = 0; link_mem[c] != 0 && guard < DICT_DEPTH; guard++) begin
         if (n < MAX_OUT_BYTES) begin
            text[n] = char_mem[c];
            n++;
         end
         t = link_mem[c] & (DICT_DEPTH - 1);
         link_mem[c] = '0;
         c = t;
      end
      if (n < MAX_OUT_BYTES) begin
         text[n] = char_mem[c];
         n++;
      end
      st = ST_OK;
      free_code++;
      if (free_code >= (32'd1 << code_bits)) begin
         if (code_bits + 1 > MAX_BITS) begin
            st = ST_OVERFLOW;
            stopped = 1'b1;
         end else begin
            code_bits++;
         end
      end
      nres = (n + 7) / 8;
      for (int k = 0; k < nres; k++) begin
         cnt = n - k * 8;
         if (cnt > 8) cnt = 8;
         r.out_bytes = '0;
         for (int j = 0; j < cnt; j++) r.out_bytes[8*j +: 8] = text[k*8 + j];
         r.byte_count  = 4'(cnt);
         r.status      = (k + 1 == nres) ? st : ST_OK;
         r.last_of_run = (k + 1 == nres);
         decoded_q.push_back(r);
      end
   endfunction

   // result side: random stall per transfer, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_request) begin
            stall_left = 200;
            hold_request = 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            stall_left = quiet ? 0 : $urandom_range(0, 5);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_data.out_bytes !== want.out_bytes) begin
               $display("%0t: out_bytes expected %h actual %h", $time,
                        want.out_bytes, rsp_data.out_bytes);
               error_count++;
            end
            if (rsp_data.byte_count !== want.byte_count) begin
               $display("%0t: byte_count expected %0d actual %0d", $time,
                        want.byte_count, rsp_data.byte_count);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $display("%0t: last_of_run expected %b actual %b", $time,
                        want.last_of_run, rsp_data.last_of_run);
               error_count++;
            end
         end
      end
   end

   task automatic send_byte(input req_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      decode_byte(item);
   endtask

   // pack codes MSB first at the width the decoder will be using
   task automatic send_codes(input int unsigned codes[$], input bit start);
      bit          bits[$];
      int unsigned w, nf;
      req_type     item;
      bit          first;
      w = START_WIDTH;
      nf = FIRST_FREE;
      foreach (codes[i]) begin
         for (int b = w - 1; b >= 0; b--) bits.push_back(bit'((codes[i] >> b) & 1));
         if (codes[i] == CLEAR_CODE) begin
            w = START_WIDTH;
            nf = FIRST_FREE;
         end else if (codes[i] != END_CODE && codes[i] < nf) begin
            nf++;
            if (nf >= (32'd1 << w) && w < MAX_BITS) w++;
         end
      end
      first = start;
      while (bits.size() > 0) begin
         item.data_byte = '0;
         for (int b = 7; b >= 0; b--)
            if (bits.size() > 0) item.data_byte[b] = bits.pop_front();
         item.first_of_stream = first;
         item.last_byte = (bits.size() == 0);
         first = 1'b0;
         send_byte(item);
      end
   endtask

   task automatic random_stream(input int len);
      int unsigned codes[$];
      int unsigned nf, pick, c;
      nf = FIRST_FREE;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            c = CLEAR_CODE;
            nf = FIRST_FREE;
         end else if (pick < 8) begin
            c = nf + $urandom_range(0, 20);
         end else if (pick < 30 && nf > FIRST_FREE) begin
            c = nf - 1;
         end else if (pick < 55 && nf > FIRST_FREE) begin
            c = $urandom_range(FIRST_FREE, nf - 1);
         end else begin
            c = $urandom_range(0, 255);
         end
         codes.push_back(c);
         if (c != CLEAR_CODE && c < nf) nf++;
         if (c >= nf) break;
      end
      if ($urandom_range(0, 1)) codes.push_back(END_CODE);
      send_codes(codes, 1'b1);
   endtask

   task automatic wait_drained();
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      req_type item;
      send_codes('{8'h41, 8'h42, 258, 259, 261, 255, 0, CLEAR_CODE, 0, 258,
                   END_CODE}, 1'b1);
      // bytes after the end code are ignored until a new stream
      item = '{data_byte: 8'hff, first_of_stream: 1'b0, last_byte: 1'b0};
      send_byte(item);
      send_codes('{300}, 1'b1);
      // single byte padded to a full code
      item = '{data_byte: 8'ha5, first_of_stream: 1'b1, last_byte: 1'b1};
      send_byte(item);
      item = '{data_byte: 8'h00, first_of_stream: 1'b0, last_byte: 1'b1};
      send_byte(item);
   endtask

   task automatic test_width_overflow();
      int unsigned codes[$];
      for (int i = 0; i < 256; i++) codes.push_back(i < 128 ? i : 258 + i - 128);
      send_codes(codes, 1'b1);
   endtask

   task automatic test_random_streams();
      for (int round = 0; round < 4; round++) begin
         quiet = (round == 3);
         random_stream($urandom_range(1, 8));
      end
      quiet = 1'b0;
   endtask

   task automatic test_noise();
      req_type item;
      for (int i = 0; i < 12; i++) begin
         item.data_byte = 8'($urandom_range(0, 255));
         item.first_of_stream = ($urandom_range(0, 7) == 0);
         item.last_byte = ($urandom_range(0, 5) == 0);
         send_byte(item);
      end
   endtask

   task automatic test_backpressure();
      req_valid <= 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      random_stream(8);
   endtask

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      error_count = 0;
      quiet = 1'b0;
      hold_request = 1'b0;
      stopped = 1'b0;
      bit_buf = 0;
      bit_cnt = 0;
      clear_dict();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_width_overflow();
      test_random_streams();
      test_backpressure();
      test_noise();
      req_valid <= 1'b0;
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
